// ----- rtl/lzssd_pkg.sv -----
// Shared types and constants for the LZSS window decoder.
// No dependencies.
package lzssd_pkg;

    localparam int unsigned WinAw = 11;
    localparam int unsigned RegW  = 31;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_FETCH   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_LOADED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NEED     = 3'd3,
        ST_COMPLETE = 3'd4,
        ST_ENDED    = 3'd5,
        ST_RESTART  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        PH_TOKEN  = 3'd0,
        PH_EXTRA  = 3'd1,
        PH_LEN_A  = 3'd2,
        PH_LEN_B  = 3'd3,
        PH_NIBBLE = 3'd4,
        PH_COPY   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_STEP,
        BS_RDWAIT,
        BS_RDDATA,
        BS_RESP
    } t_bstate;

    localparam logic [1:0] RegOutLen    = 2'd0;
    localparam logic [1:0] RegPackedLen = 2'd1;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_resp;

endpackage

// ----- rtl/lzssd_front.sv -----
// Front end: takes requests, classifies them, and queues them for the back end.
// Depends on lzssd_pkg.
module lzssd_front #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [1:0]           s_axis_tuser,   // command[1:0]
    input  logic [7:0]           s_axis_tdata,   // data_byte[7:0]
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output lzssd_pkg::t_cmd      o_q_cmd,
    output logic [7:0]           o_q_byte
);
    import lzssd_pkg::*;

    localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    logic [9:0]     r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    t_cmd           w_cmd;

    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_cnt != QDEPTH[QAW:0]);
    // unused command code is dropped here and never reaches the back end
    assign w_push        = s_axis_tvalid && s_axis_tready && (w_cmd != CMD_NONE);
    assign o_q_valid     = (r_cnt != '0);
    assign o_q_cmd       = t_cmd'(r_q[r_rp][1:0]);
    assign o_q_byte      = r_q[r_rp][9:2];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= {s_axis_tdata, s_axis_tuser};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_q_pop);
        end
    end
endmodule

// ----- rtl/lzssd_back.sv -----
// Back end: input byte buffer, bit reader, token decoder and history window.
// Depends on lzssd_pkg.
module lzssd_back #(
    parameter int unsigned IBDEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  lzssd_pkg::t_cmd        i_q_cmd,
    input  logic [7:0]             i_q_byte,
    input  logic [30:0]            i_out_len,
    input  logic [30:0]            i_packed_len,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lzssd_pkg::t_resp       o_resp
);
    import lzssd_pkg::*;

    localparam int unsigned IBAW = (IBDEPTH > 1) ? $clog2(IBDEPTH) : 1;
    localparam int unsigned IBCW = $clog2(IBDEPTH + 1);
    localparam int unsigned WinDepth = 1 << WinAw;

    // history window memory
    logic [7:0]       r_win [WinDepth];
    logic [WinAw-1:0] r_wa, r_ra;
    logic [7:0]       r_wd, r_rd;
    logic             r_we;

    always_ff @(posedge i_clk) begin
        if (r_we) r_win[r_wa] <= r_wd;
        r_rd <= r_win[r_ra];
    end

    // input byte buffer (circular)
    logic [7:0]      r_ib [IBDEPTH];
    logic [IBAW-1:0] r_ib_wp, r_ib_rp;
    logic [IBCW-1:0] r_ib_cnt;

    t_bstate          r_st;
    logic [WinAw-1:0] r_wpos, r_clr;
    logic [31:0]      r_acc, r_pc, r_oc, r_rem;
    logic [5:0]       r_bc;
    t_phase           r_ph;
    logic [WinAw-1:0] r_dist;
    logic             r_ended;
    t_resp            r_resp;
    logic             r_valid;

    assign o_valid = r_valid;
    assign o_resp  = r_resp;

    // bit reader view
    logic [3:0]  w_need;
    logic        w_have;
    logic [8:0]  w_v;
    logic [31:0] w_oc1, w_sum;
    logic [32:0] w_sat;
    logic [5:0]  w_sh;

    always_comb begin
        unique case (r_ph)
            PH_TOKEN:            w_need = 4'd9;
            PH_EXTRA, PH_NIBBLE: w_need = 4'd4;
            default:             w_need = 4'd2;
        endcase
        w_have = (r_bc >= {2'b0, w_need});
        w_v    = 9'(r_acc >> (6'd32 - {2'b0, w_need}));
        w_oc1  = r_oc + 32'd1;
        w_sat  = {1'b0, r_rem} + 33'(w_v[3:0]) + ((w_v[3:0] != 4'hf) ? 33'd2 : 33'd0);
        w_sum  = w_sat[32] ? 32'hffff_ffff : w_sat[31:0];
        w_sh   = 6'd24 - r_bc;
    end

    logic r_pop;
    assign o_q_pop = r_pop;

    always_ff @(posedge i_clk) begin
        // every idle-state request pops the queue; window writes come from
        // the clear sweep, a literal, or a copied byte
        r_pop <= i_rst_n && (r_st == BS_IDLE) && i_q_valid && !r_pop && !r_valid;
        r_we  <= i_rst_n && ((r_st == BS_CLEAR) || (r_st == BS_RDDATA) ||
                 ((r_st == BS_STEP) && (r_ph == PH_TOKEN) && w_have && !w_v[8]));
        if (!i_rst_n) begin
            r_st    <= BS_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_ib_wp <= '0; r_ib_rp <= '0; r_ib_cnt <= '0;
            r_wpos <= '0; r_acc <= '0; r_bc <= '0; r_pc <= '0; r_oc <= '0;
            r_ph <= PH_TOKEN; r_dist <= '0; r_rem <= '0; r_ended <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_st)
                BS_CLEAR: begin
                    r_wa <= r_clr; r_wd <= '0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_st <= BS_IDLE;
                end
                BS_IDLE: begin
                    if (i_q_valid && !r_pop && !r_valid) begin
                        unique case (i_q_cmd)
                            CMD_LOAD: begin
                                if (r_ib_cnt >= IBCW'(IBDEPTH)) begin
                                    r_resp <= '{data: 8'd0, status: ST_FULL, last: 1'b0};
                                end else begin
                                    r_ib[r_ib_wp] <= i_q_byte;
                                    r_ib_wp <= (r_ib_wp == IBAW'(IBDEPTH-1)) ? '0 : r_ib_wp+1'b1;
                                    r_ib_cnt <= r_ib_cnt + 1'b1;
                                    r_resp <= '{data: 8'd0, status: ST_LOADED, last: 1'b0};
                                end
                                r_valid <= 1'b1;
                            end
                            CMD_RESTART: begin
                                r_ib_wp <= '0; r_ib_rp <= '0; r_ib_cnt <= '0;
                                r_wpos <= '0; r_acc <= '0; r_bc <= '0; r_pc <= '0;
                                r_oc <= '0; r_ph <= PH_TOKEN; r_dist <= '0;
                                r_rem <= '0; r_ended <= 1'b0;
                                r_resp <= '{data: 8'd0, status: ST_RESTART, last: 1'b0};
                                r_clr <= '0;
                                r_st <= BS_RESP;
                            end
                            CMD_FETCH: begin
                                if (r_oc >= {1'b0, i_out_len}) begin
                                    r_resp <= '{data: 8'd0, status: ST_COMPLETE, last: 1'b0};
                                    r_valid <= 1'b1;
                                end else if (r_ended) begin
                                    r_resp <= '{data: 8'd0, status: ST_ENDED, last: 1'b0};
                                    r_valid <= 1'b1;
                                end else begin
                                    r_resp <= '{data: 8'd0, status: ST_BYTE, last: 1'b0};
                                    r_st <= BS_STEP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                BS_RESP: begin
                    // restart: respond, then sweep the window
                    r_valid <= 1'b1;
                    r_st <= BS_CLEAR;
                end
                BS_STEP: begin
                    if (r_ph == PH_COPY) begin
                        if (r_rem == '0) begin
                            r_ph <= PH_TOKEN;
                        end else begin
                            r_rem <= r_rem - 1'b1;
                            if (r_rem == 32'd1) r_ph <= PH_TOKEN;
                            r_ra <= r_wpos - r_dist;
                            r_st <= BS_RDWAIT;
                        end
                    end else if (!w_have) begin
                        // pull one byte, or zeros at the packed length, into the accumulator; else stop
                        if (r_pc > {1'b0, i_packed_len}) begin
                            r_ended <= 1'b1; r_resp.status <= ST_ENDED;
                            r_valid <= 1'b1; r_st <= BS_IDLE;
                        end else if (r_pc < {1'b0, i_packed_len}) begin
                            if (r_ib_cnt == '0) begin
                                r_resp.status <= ST_NEED;
                                r_valid <= 1'b1; r_st <= BS_IDLE;
                            end else begin
                                r_acc <= r_acc + ({24'd0, r_ib[r_ib_rp]} << w_sh);
                                r_ib_rp <= (r_ib_rp == IBAW'(IBDEPTH-1)) ? '0 : r_ib_rp+1'b1;
                                r_ib_cnt <= r_ib_cnt - 1'b1;
                                r_pc <= r_pc + 1'b1;
                                r_bc <= r_bc + 6'd8;
                            end
                        end else begin
                            r_pc <= r_pc + 1'b1;
                            r_bc <= r_bc + 6'd8;
                        end
                    end else begin
                        r_acc <= r_acc << w_need;
                        r_bc  <= r_bc - {2'b0, w_need};
                        unique case (r_ph)
                            PH_TOKEN: begin
                                if (!w_v[8]) begin
                                    r_wa <= r_wpos; r_wd <= w_v[7:0];
                                    r_wpos <= r_wpos + 1'b1; r_oc <= w_oc1;
                                    r_resp.data <= w_v[7:0];
                                    r_resp.last <= (w_oc1 == {1'b0, i_out_len});
                                    r_valid <= 1'b1; r_st <= BS_IDLE;
                                end else if (w_v[7:0] == 8'h81) begin
                                    r_dist <= 11'd1; r_ph <= PH_LEN_A;
                                end else if (!w_v[7]) begin
                                    r_dist <= {4'd0, w_v[6:0]}; r_ph <= PH_EXTRA;
                                end else if (w_v[6:0] == '0) begin
                                    r_ended <= 1'b1; r_resp.status <= ST_ENDED;
                                    r_valid <= 1'b1; r_st <= BS_IDLE;
                                end else begin
                                    r_dist <= {4'd0, w_v[6:0]}; r_ph <= PH_LEN_A;
                                end
                            end
                            PH_EXTRA: begin
                                r_dist <= {r_dist[6:0], w_v[3:0]}; r_ph <= PH_LEN_A;
                            end
                            PH_LEN_A: begin
                                if (w_v[1:0] == 2'd3) begin
                                    r_rem <= 32'd3; r_ph <= PH_LEN_B;
                                end else begin
                                    r_rem <= 32'(w_v[1:0]) + 32'd2; r_ph <= PH_COPY;
                                end
                            end
                            PH_LEN_B: begin
                                if (w_v[1:0] == 2'd3) begin
                                    r_rem <= r_rem + 32'd3; r_ph <= PH_NIBBLE;
                                end else begin
                                    r_rem <= r_rem + 32'(w_v[1:0]) + 32'd2; r_ph <= PH_COPY;
                                end
                            end
                            default: begin
                                r_rem <= w_sum;
                                if (w_v[3:0] != 4'hf) r_ph <= PH_COPY;
                            end
                        endcase
                    end
                end
                BS_RDWAIT: r_st <= BS_RDDATA;
                BS_RDDATA: begin
                    r_wa <= r_wpos; r_wd <= r_rd;
                    r_wpos <= r_wpos + 1'b1; r_oc <= w_oc1;
                    r_resp.data <= r_rd;
                    r_resp.last <= (w_oc1 == {1'b0, i_out_len});
                    r_valid <= 1'b1; r_st <= BS_IDLE;
                end
                default: r_st <= BS_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/lzss_window_decoder.sv -----
// LZSS decoder with a 2048-byte history window, stream request interface.
// A fetch pulls packed bytes, parses token fields and copies window bytes as needed.
// One request is worked at a time by the back end; the front queue holds two.
// Reset (sync, active low) and restart sweep the window, during which no request
// is worked. Depends on lzssd_pkg, lzssd_front, lzssd_back.
module lzss_window_decoder #(
    parameter int unsigned INPUT_BUFFER_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import lzssd_pkg::*;

    logic [30:0] r_out_len, r_packed_len;
    logic        w_qv, w_pop;
    t_cmd        w_cmd;
    logic [7:0]  w_qb;
    t_resp       w_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len    <= '0;
            r_packed_len <= '0;
        end else if (i_cfg_we) begin
            if ({1'b0, i_cfg_index} == RegOutLen)    r_out_len    <= i_cfg_data;
            if ({1'b0, i_cfg_index} == RegPackedLen) r_packed_len <= i_cfg_data;
        end
    end

    lzssd_front #(.QDEPTH(2)) u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_cmd(w_cmd), .o_q_byte(w_qb)
    );

    lzssd_back #(.IBDEPTH(INPUT_BUFFER_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_cmd(w_cmd),
        .i_q_byte(w_qb), .i_out_len(r_out_len), .i_packed_len(r_packed_len),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_resp(w_resp)
    );

    assign m_axis_tdata = w_resp.data;
    assign m_axis_tuser = w_resp.status;
    assign m_axis_tlast = w_resp.last;
endmodule
